// ===== src/ipgd_pkg.sv =====
// shared constants and types for the ir pulse-gap packet decoder
package ipgd_pkg;

	localparam int STACK_DEPTH = 16;
	localparam int MAX_GAPS    = 32;

	localparam int TS_W     = 32;
	localparam int PKT_W    = 32;
	localparam int GAP_W    = 16;
	localparam int TIME_W   = 24;
	localparam int CFG_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int GC_W     = $clog2(MAX_GAPS + 1);
	localparam int DIV_STEPS = GAP_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int SHIFT_W  = $clog2(PKT_W);

	localparam logic [CFG_IDX_W-1:0] REG_BIT_TIME        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP         = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP         = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_PACKET_TIME = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_TIME = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NO_PACKET_CODE  = 3'd5;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [GAP_W-1:0]  BIT_TIME_RST        = 16'd500;
	localparam logic [GAP_W-1:0]  MIN_GAP_RST         = 16'd250;
	localparam logic [GAP_W-1:0]  MAX_GAP_RST         = 16'd4000;
	localparam logic [TIME_W-1:0] MIN_PACKET_TIME_RST = 24'd15000;
	localparam logic [TIME_W-1:0] MAX_PACKET_TIME_RST = 24'd40000;
	localparam logic [PKT_W-1:0]  NO_PACKET_CODE_RST  = 32'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FOLD,
		ST_POP
	} state_t;

endpackage

// ===== src/ir_pulse_gap_packet_decoder.sv =====
// ir pulse-gap packet decoder: gap rounding, packet assembly and a packet stack in memory
//
//  channel   dir  signals                          word contents
//  s_        in   s_tvalid s_tready s_tdata s_tuser  tdata: timestamp, tuser: operation
//  m_        out  m_tvalid m_tready m_tdata m_tuser  tdata: packet, tuser: empty_res
//  cfg_      in   cfg_we cfg_index cfg_data          register write, no handshake
//
// an edge word passes through accept, gap check, 16 divider steps, then fold and push;
// the divider for gap/bit_time is a 1-bit-per-cycle restoring divider
// an edge that restarts the packet skips the divider; a pop waits out any output stall
// the packet stack is a 1-port-write, 1-port-read memory with a registered read
// arst_n clears all control state and config registers; stack contents are not cleared
module ir_pulse_gap_packet_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [ipgd_pkg::TS_W-1:0]     s_tdata,   // [31:0] timestamp
	input  logic                          s_tuser,   // [0] operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [ipgd_pkg::PKT_W-1:0]    m_tdata,   // [31:0] packet
	output logic                          m_tuser,   // [0] empty_res
	input  logic                          cfg_we,
	input  logic [ipgd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ipgd_pkg::CFG_W-1:0]    cfg_data
);

	ipgd_pkg::state_t state_q, state_nx;

	logic [ipgd_pkg::GAP_W-1:0]  bit_time_q, min_gap_q, max_gap_q;
	logic [ipgd_pkg::TIME_W-1:0] min_pt_q, max_pt_q;
	logic [ipgd_pkg::PKT_W-1:0]  npc_q;

	logic [ipgd_pkg::TS_W-1:0]   last_edge_q, start_q;
	logic [ipgd_pkg::GC_W-1:0]   gap_count_q;
	logic [ipgd_pkg::PKT_W-1:0]  acc_q;
	logic                        zs_q;
	logic [ipgd_pkg::CNT_W-1:0]  count_q;

	logic [ipgd_pkg::TS_W-1:0]   t_s1, gap_s1, elapsed_s1;

	logic [ipgd_pkg::GAP_W-1:0]  rem_q, quo_q;
	logic [ipgd_pkg::DIV_CNT_W-1:0] div_cnt_q;

	logic                        pop_empty_q;
	logic [ipgd_pkg::PKT_W-1:0]  rd_data_q;
	logic [ipgd_pkg::PKT_W-1:0]  mem [ipgd_pkg::STACK_DEPTH];

	logic                        out_valid_q, out_empty_q;
	logic [ipgd_pkg::PKT_W-1:0]  out_packet_q;

	logic                        in_acc, is_pop, restart, out_free, out_load;
	logic [ipgd_pkg::GAP_W-1:0]  bt;
	logic [ipgd_pkg::GAP_W:0]    shifted;
	logic                        qbit;
	logic                        round_up;
	logic [ipgd_pkg::GAP_W:0]    slots;
	logic                        fold_en;
	logic [ipgd_pkg::PKT_W-1:0]  acc_f, word;
	logic                        zs_f, complete, push, rd_en;
	logic [ipgd_pkg::ADDR_W-1:0] rd_addr, wr_addr;
	logic [ipgd_pkg::CNT_W-1:0]  count_dec;

	assign s_tready = (state_q == ipgd_pkg::ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign is_pop   = (s_tuser == ipgd_pkg::OP_POP);
	assign out_free = !out_valid_q || m_tready;

	assign bt = (bit_time_q == '0) ? ipgd_pkg::GAP_W'(1) : bit_time_q;

	assign restart = (gap_s1 > {{(ipgd_pkg::TS_W - ipgd_pkg::GAP_W){1'b0}}, max_gap_q})
		|| (gap_s1 < {{(ipgd_pkg::TS_W - ipgd_pkg::GAP_W){1'b0}}, min_gap_q})
		|| (elapsed_s1 > {{(ipgd_pkg::TS_W - ipgd_pkg::TIME_W){1'b0}}, max_pt_q})
		|| (gap_count_q >= ipgd_pkg::GC_W'(ipgd_pkg::MAX_GAPS));

	// restoring divider step
	assign shifted = {rem_q, quo_q[ipgd_pkg::GAP_W-1]};
	assign qbit    = (shifted >= {1'b0, bt});

	// rounding and fold
	assign round_up = ({rem_q, 1'b0} >= {1'b0, bt});
	assign slots    = {1'b0, quo_q} + {{ipgd_pkg::GAP_W{1'b0}}, round_up};
	assign fold_en  = (gap_count_q != '0) && !zs_q;

	always_comb begin
		acc_f = acc_q;
		zs_f  = zs_q;
		if (fold_en) begin
			if (slots == '0) begin
				zs_f = 1'b1;
			end else if (slots >= (ipgd_pkg::GAP_W + 1)'(ipgd_pkg::PKT_W)) begin
				acc_f = '0;
			end else begin
				acc_f = (acc_q | ipgd_pkg::PKT_W'(1)) << slots[ipgd_pkg::SHIFT_W-1:0];
			end
		end
	end

	assign complete  = (elapsed_s1 >= {{(ipgd_pkg::TS_W - ipgd_pkg::TIME_W){1'b0}}, min_pt_q});
	assign word      = zs_f ? (npc_q | ipgd_pkg::PKT_W'(1)) : (acc_f | ipgd_pkg::PKT_W'(1));
	assign count_dec = count_q - ipgd_pkg::CNT_W'(1);
	assign rd_addr   = count_dec[ipgd_pkg::ADDR_W-1:0];
	assign wr_addr   = count_q[ipgd_pkg::ADDR_W-1:0];

	always_comb begin
		state_nx = state_q;
		rd_en    = 1'b0;
		push     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ipgd_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (is_pop) begin
						rd_en    = (count_q != '0);
						state_nx = ipgd_pkg::ST_POP;
					end else begin
						state_nx = ipgd_pkg::ST_CHECK;
					end
				end
			end
			ipgd_pkg::ST_CHECK: begin
				state_nx = restart ? ipgd_pkg::ST_IDLE : ipgd_pkg::ST_DIV;
			end
			ipgd_pkg::ST_DIV: begin
				if (div_cnt_q == ipgd_pkg::DIV_CNT_W'(ipgd_pkg::DIV_STEPS - 1)) begin
					state_nx = ipgd_pkg::ST_FOLD;
				end
			end
			ipgd_pkg::ST_FOLD: begin
				push     = complete && (count_q < ipgd_pkg::CNT_W'(ipgd_pkg::STACK_DEPTH));
				state_nx = ipgd_pkg::ST_IDLE;
			end
			ipgd_pkg::ST_POP: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = ipgd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = ipgd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ipgd_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_time_q <= ipgd_pkg::BIT_TIME_RST;
			min_gap_q  <= ipgd_pkg::MIN_GAP_RST;
			max_gap_q  <= ipgd_pkg::MAX_GAP_RST;
			min_pt_q   <= ipgd_pkg::MIN_PACKET_TIME_RST;
			max_pt_q   <= ipgd_pkg::MAX_PACKET_TIME_RST;
			npc_q      <= ipgd_pkg::NO_PACKET_CODE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ipgd_pkg::REG_BIT_TIME:        bit_time_q <= cfg_data[ipgd_pkg::GAP_W-1:0];
				ipgd_pkg::REG_MIN_GAP:         min_gap_q  <= cfg_data[ipgd_pkg::GAP_W-1:0];
				ipgd_pkg::REG_MAX_GAP:         max_gap_q  <= cfg_data[ipgd_pkg::GAP_W-1:0];
				ipgd_pkg::REG_MIN_PACKET_TIME: min_pt_q   <= cfg_data[ipgd_pkg::TIME_W-1:0];
				ipgd_pkg::REG_MAX_PACKET_TIME: max_pt_q   <= cfg_data[ipgd_pkg::TIME_W-1:0];
				ipgd_pkg::REG_NO_PACKET_CODE:  npc_q      <= cfg_data[ipgd_pkg::PKT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_edge_q <= '0;
			start_q     <= '0;
			gap_count_q <= '0;
			acc_q       <= '0;
			zs_q        <= 1'b0;
			count_q     <= '0;
			pop_empty_q <= 1'b0;
		end else begin
			if (in_acc && !is_pop) begin
				last_edge_q <= s_tdata;
			end
			if (in_acc && is_pop) begin
				pop_empty_q <= (count_q == '0);
				if (count_q != '0) begin
					count_q <= count_dec;
				end
			end
			if (state_q == ipgd_pkg::ST_CHECK && restart) begin
				acc_q       <= '0;
				zs_q        <= 1'b0;
				start_q     <= t_s1;
				gap_count_q <= ipgd_pkg::GC_W'(1);
			end
			if (state_q == ipgd_pkg::ST_FOLD) begin
				if (complete) begin
					last_edge_q <= '0;
					acc_q       <= '0;
					zs_q        <= 1'b0;
					gap_count_q <= ipgd_pkg::GC_W'(1);
				end else begin
					acc_q       <= acc_f;
					zs_q        <= zs_f;
					gap_count_q <= gap_count_q + ipgd_pkg::GC_W'(1);
				end
				if (push) begin
					count_q <= count_q + ipgd_pkg::CNT_W'(1);
				end
			end
		end
	end

	// edge capture and divider datapath
	always_ff @(posedge clk) begin
		if (in_acc && !is_pop) begin
			t_s1       <= s_tdata;
			gap_s1     <= s_tdata - last_edge_q;
			elapsed_s1 <= s_tdata - start_q;
		end
		if (state_q == ipgd_pkg::ST_CHECK) begin
			rem_q     <= '0;
			quo_q     <= gap_s1[ipgd_pkg::GAP_W-1:0];
			div_cnt_q <= '0;
		end else if (state_q == ipgd_pkg::ST_DIV) begin
			rem_q     <= qbit ? ipgd_pkg::GAP_W'(shifted - {1'b0, bt})
				: shifted[ipgd_pkg::GAP_W-1:0];
			quo_q     <= {quo_q[ipgd_pkg::GAP_W-2:0], qbit};
			div_cnt_q <= div_cnt_q + ipgd_pkg::DIV_CNT_W'(1);
		end
	end

	// packet stack memory
	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_addr] <= word;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_packet_q <= pop_empty_q ? npc_q : rd_data_q;
			out_empty_q  <= pop_empty_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_packet_q;
	assign m_tuser  = out_empty_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ipgd_pkg::CNT_W'(ipgd_pkg::STACK_DEPTH))
		else $error("stack count above depth");

	a_gap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		gap_count_q <= ipgd_pkg::GC_W'(ipgd_pkg::MAX_GAPS))
		else $error("gap count above limit");

	a_pop_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && is_pop) |=> (state_q == ipgd_pkg::ST_POP))
		else $error("pop word not routed to output stage");

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> m_tvalid)
		else $error("loaded result not presented");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (state_q == ipgd_pkg::ST_FOLD) && (count_q != ipgd_pkg::CNT_W'(ipgd_pkg::STACK_DEPTH)))
		else $error("push into a full stack");
`endif

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the ir pulse-gap packet decoder: directed corners, then random packets
`timescale 1ns / 100ps

module testbench;
	import ipgd_pkg::*;

	localparam int WORD_GOAL      = 1500;
	localparam int QUIET_CYCLES   = 40;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = REG_NO_PACKET_CODE + 3'd1;

	typedef struct packed {
		logic [PKT_W-1:0] packet;
		logic             empty_res;
	} popped_word_t;

	typedef struct packed {
		logic [GAP_W-1:0]  bit_time;
		logic [GAP_W-1:0]  min_gap;
		logic [GAP_W-1:0]  max_gap;
		logic [TIME_W-1:0] min_pkt_time;
		logic [TIME_W-1:0] max_pkt_time;
		logic [PKT_W-1:0]  no_pkt_code;
	} decoder_settings_t;

	class packet_stack_tracker;
		logic [GAP_W-1:0]  bit_time, min_gap, max_gap;
		logic [TIME_W-1:0] min_pkt_time, max_pkt_time;
		logic [PKT_W-1:0]  no_pkt_code;
		logic [TS_W-1:0]   last_fall, start_stamp;
		logic [PKT_W-1:0]  accum;
		int unsigned       gap_count;
		bit                zero_slot;
		logic [PKT_W-1:0]  stack_words[$];
		popped_word_t      expected_pops[$];
		int                mismatches;

		function new();
			bit_time     = BIT_TIME_RST;
			min_gap      = MIN_GAP_RST;
			max_gap      = MAX_GAP_RST;
			min_pkt_time = MIN_PACKET_TIME_RST;
			max_pkt_time = MAX_PACKET_TIME_RST;
			no_pkt_code  = NO_PACKET_CODE_RST;
			last_fall    = '0;
			start_stamp  = '0;
			accum        = '0;
			gap_count    = 0;
			zero_slot    = 1'b0;
			mismatches   = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
			case (idx)
				REG_BIT_TIME:        bit_time     = value[GAP_W-1:0];
				REG_MIN_GAP:         min_gap      = value[GAP_W-1:0];
				REG_MAX_GAP:         max_gap      = value[GAP_W-1:0];
				REG_MIN_PACKET_TIME: min_pkt_time = value[TIME_W-1:0];
				REG_MAX_PACKET_TIME: max_pkt_time = value[TIME_W-1:0];
				REG_NO_PACKET_CODE:  no_pkt_code  = value[PKT_W-1:0];
				default: ;
			endcase
		endfunction

		function void fold_fall(logic [TS_W-1:0] stamp);
			logic [TS_W-1:0]  gap, since;
			logic [PKT_W-1:0] word;
			longint unsigned  div, slots;
			gap       = stamp - last_fall;
			since     = stamp - start_stamp;
			last_fall = stamp;
			if (gap > 32'(max_gap) || gap < 32'(min_gap) || since > 32'(max_pkt_time) ||
					gap_count >= MAX_GAPS) begin
				accum       = '0;
				zero_slot   = 1'b0;
				start_stamp = stamp;
				gap_count   = 1;
			end else begin
				div   = (bit_time == '0) ? 64'd1 : 64'(bit_time);
				slots = (64'(gap) * 64'd2 + div) / (div * 64'd2);
				if (gap_count >= 1 && !zero_slot) begin
					if (slots == 0)
						zero_slot = 1'b1;
					else if (slots >= PKT_W)
						accum = '0;
					else
						accum = (accum | 32'd1) << slots;
				end
				gap_count++;
				if (since >= 32'(min_pkt_time)) begin
					word = zero_slot ? (no_pkt_code | 32'd1) : (accum | 32'd1);
					if (stack_words.size() < STACK_DEPTH)
						stack_words.push_back(word);
					last_fall = '0;
					accum     = '0;
					zero_slot = 1'b0;
					gap_count = 1;
				end
			end
		endfunction

		function void note_word(logic op, logic [TS_W-1:0] stamp);
			popped_word_t r;
			if (op == OP_POP) begin
				if (stack_words.size() == 0) begin
					r.packet    = no_pkt_code;
					r.empty_res = 1'b1;
				end else begin
					r.packet    = stack_words.pop_back();
					r.empty_res = 1'b0;
				end
				expected_pops.push_back(r);
			end else begin
				fold_fall(stamp);
			end
		endfunction

		function void check_pop(logic [PKT_W-1:0] packet, logic empty_res);
			popped_word_t r;
			if (expected_pops.size() == 0) begin
				$error("unexpected word: packet %h empty_res %0b", packet, empty_res);
				mismatches++;
			end else begin
				r = expected_pops.pop_front();
				if (packet !== r.packet) begin
					$error("packet expected %h actual %h", r.packet, packet);
					mismatches++;
				end
				if (empty_res !== r.empty_res) begin
					$error("empty_res expected %0b actual %0b", r.empty_res, empty_res);
					mismatches++;
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [TS_W-1:0]      s_tdata;   // [31:0] timestamp
	logic                 s_tuser;   // [0] operation
	logic                 m_tvalid;
	logic                 m_tready;
	logic [PKT_W-1:0]     m_tdata;   // [31:0] packet
	logic                 m_tuser;   // [0] empty_res
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	packet_stack_tracker tracker;
	decoder_settings_t   cur;
	int                  words_sent;
	int                  burst_left;
	int                  idle_cycles;
	int                  rx_hold;
	bit                  rx_open;
	bit                  tx_steady;
	bit                  rx_steady;

	ir_pulse_gap_packet_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// receiver stall pattern
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_open = !rx_open;
			if (rx_open)
				rx_hold = $urandom_range(1, 12);
			else if ($urandom_range(0, 4) == 0)
				rx_hold = $urandom_range(6, 30);
			else
				rx_hold = $urandom_range(1, 3);
		end
		rx_hold--;
		m_tready <= rx_steady || rx_open;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			idle_cycles++;
			if (m_tvalid && m_tready) begin
				tracker.check_pop(m_tdata, m_tuser);
				idle_cycles = 0;
			end
			if (s_tvalid && s_tready) begin
				tracker.note_word(s_tuser, s_tdata);
				idle_cycles = 0;
			end
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	task automatic send_word(logic op, logic [TS_W-1:0] stamp);
		int pause;
		if (burst_left == 0) begin
			pause      = (tx_steady || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 24);
			if (pause > 0) begin
				s_tvalid <= 1'b0;
				repeat (pause) @(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= stamp;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		words_sent++;
		@(negedge clk);
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		tracker.set_register(idx, value);
		@(negedge clk);
	endtask

	task automatic load_settings(decoder_settings_t s);
		put_reg(REG_BIT_TIME, 32'(s.bit_time));
		put_reg(REG_MIN_GAP, 32'(s.min_gap));
		put_reg(REG_MAX_GAP, 32'(s.max_gap));
		put_reg(REG_MIN_PACKET_TIME, 32'(s.min_pkt_time));
		put_reg(REG_MAX_PACKET_TIME, 32'(s.max_pkt_time));
		put_reg(REG_NO_PACKET_CODE, s.no_pkt_code);
		put_reg(REG_UNKNOWN, $urandom());
		cfg_we <= 1'b0;
		cur = s;
	endtask

	// drain outstanding pops and let a pending edge finish before touching registers
	task automatic settle();
		s_tvalid <= 1'b0;
		while (tracker.expected_pops.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic decoder_settings_t corner_settings(int which);
		decoder_settings_t s;
		case (which)
			0: s = '{bit_time: 16'd0, min_gap: 16'd0, max_gap: 16'hFFFF, min_pkt_time: 24'd0,
				max_pkt_time: 24'hFF_FFFF, no_pkt_code: 32'hFFFF_FFFF};
			1: s = '{bit_time: 16'hFFFF, min_gap: 16'hFFFF, max_gap: 16'hFFFF,
				min_pkt_time: 24'hFF_FFFF, max_pkt_time: 24'hFF_FFFF, no_pkt_code: 32'd0};
			default: s = '{bit_time: 16'd1, min_gap: 16'd1, max_gap: 16'd40, min_pkt_time: 24'd30,
				max_pkt_time: 24'd0, no_pkt_code: 32'h8000_0000};
		endcase
		return s;
	endfunction

	function automatic decoder_settings_t random_settings();
		decoder_settings_t s;
		longint unsigned   bt, mg, k, mp;
		bt = $urandom_range(1, 3000);
		mg = bt * $urandom_range(3, 40);
		if (mg > 65535)
			mg = 65535;
		k  = $urandom_range(1, 16);
		mp = k * 2 * bt + mg + $urandom_range(0, 32'(8 * bt));
		if ($urandom_range(0, 7) == 0)
			mp = k * bt;
		s.bit_time     = 16'(bt);
		s.min_gap      = 16'($urandom_range(32'(bt / 4), 32'(bt * 3 / 4)));
		s.max_gap      = 16'(mg);
		s.min_pkt_time = 24'(k * 2 * bt);
		s.max_pkt_time = 24'(mp);
		s.no_pkt_code  = $urandom();
		return s;
	endfunction

	// one packet of falling edges with mostly well-formed gaps, with some pops mixed in
	task automatic send_packet(int pop_rate);
		longint          bt, lo, hi, gap, elapsed;
		logic [TS_W-1:0] t;
		int              n, roll;
		bt = (cur.bit_time == '0) ? 1 : longint'(cur.bit_time);
		lo = cur.min_gap;
		hi = cur.max_gap;
		t  = $urandom();
		send_word(OP_EDGE, t);
		elapsed = 0;
		for (n = 0; n < 40 && elapsed < longint'(cur.min_pkt_time); n++) begin
			roll = $urandom_range(0, 99);
			if (roll < pop_rate / 4) begin
				send_word(OP_POP, $urandom());
			end else begin
				if (roll < 3) begin
					gap = longint'($urandom_range(0, 32'(lo)));
				end else if (roll < 5) begin
					gap = hi + longint'($urandom_range(1, 2000));
				end else if (roll < 8) begin
					gap = longint'($urandom_range(0, 32'(bt / 2)));
				end else begin
					gap = longint'((roll < 10) ? $urandom_range(30, 40) : $urandom_range(1, 3)) * bt
						+ longint'($urandom_range(0, 32'(2 * (bt / 3)))) - bt / 3;
					if (gap < lo)
						gap = lo;
					if (gap > hi && hi >= lo)
						gap = hi;
				end
				if (gap < 0)
					gap = 0;
				t = t + 32'(gap);
				if (gap < lo || gap > hi)
					elapsed = 0;
				else
					elapsed += gap;
				send_word(OP_EDGE, t);
			end
		end
	endtask

	initial begin
		decoder_settings_t s;
		logic [TS_W-1:0]   t;
		int                default_gaps[7];
		int                phase, phase_end, pop_rate, roll;
		clk         = 1'b0;
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tuser     = OP_EDGE;
		s_tdata     = '0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_BIT_TIME;
		cfg_data    = '0;
		words_sent  = 0;
		burst_left  = 0;
		idle_cycles = 0;
		rx_hold     = 0;
		rx_open     = 1'b0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		tracker     = new();
		cur         = '{bit_time: BIT_TIME_RST, min_gap: MIN_GAP_RST, max_gap: MAX_GAP_RST,
			min_pkt_time: MIN_PACKET_TIME_RST, max_pkt_time: MAX_PACKET_TIME_RST,
			no_pkt_code: NO_PACKET_CODE_RST};
		default_gaps = '{250, 4000, 749, 750, 4000, 4000, 2250};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: empty pop, first gap only counted, long and short gap restarts
		send_word(OP_POP, 32'hFFFF_FFFF);
		send_word(OP_EDGE, 32'd1000);
		send_word(OP_EDGE, 32'd2000);
		send_word(OP_EDGE, 32'd18000);
		t = 32'd18249;
		send_word(OP_EDGE, t);
		foreach (default_gaps[i]) begin
			t = t + default_gaps[i];
			send_word(OP_EDGE, t);
		end
		send_word(OP_POP, 32'd0);
		settle();

		// zero-slot gap, time wrap, half-range gap, oversized shift
		s = '{bit_time: 16'd1000, min_gap: 16'd0, max_gap: 16'hFFFF, min_pkt_time: 24'd40000,
			max_pkt_time: 24'hFF_FFFF, no_pkt_code: 32'hA5A5_0000};
		load_settings(s);
		t = 32'hFFFF_0000;
		send_word(OP_EDGE, t);
		t = t + 32'd100;
		send_word(OP_EDGE, t);
		t = t + 32'd40000;
		send_word(OP_EDGE, t);
		t = 32'h8000_0000;
		send_word(OP_EDGE, t);
		t = t + 32'd35000;
		send_word(OP_EDGE, t);
		t = t + 32'd5000;
		send_word(OP_EDGE, t);
		repeat (3) send_word(OP_POP, $urandom());
		settle();

		phase = 0;
		words_sent = 0;
		while (words_sent < WORD_GOAL) begin
			s = (phase < 3) ? corner_settings(phase) : random_settings();
			load_settings(s);
			case ($urandom_range(0, 3))
				0: pop_rate = 0;
				1: pop_rate = 10;
				2: pop_rate = 25;
				default: pop_rate = 45;
			endcase
			tx_steady = ($urandom_range(0, 3) == 0);
			rx_steady = ($urandom_range(0, 3) == 0);
			phase_end = words_sent + $urandom_range(60, 180);
			while (words_sent < phase_end) begin
				roll = $urandom_range(0, 99);
				if (roll < pop_rate)
					send_word(OP_POP, $urandom());
				else if (roll < pop_rate + 8)
					send_word(OP_EDGE, $urandom());
				else
					send_packet(pop_rate);
			end
			// stack filled without pops: empty it and two past
			if (pop_rate == 0)
				repeat (tracker.stack_words.size() + 2) send_word(OP_POP, $urandom());
			settle();
			phase++;
		end

		if (tracker.mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

// ===== files.f =====
src/ipgd_pkg.sv
src/ir_pulse_gap_packet_decoder.sv
bench/testbench.sv
